@@ rtl/core/dbpr_pkg.sv @@
package dbpr_pkg;

  // default sizing
  localparam int unsigned REGION_PAGES_DEF = 512;
  localparam int unsigned OUT_WORDS_DEF    = 64;

  // field widths
  localparam int unsigned PAGE_W     = 9;
  localparam int unsigned CS_W       = 6;
  localparam int unsigned SS_W       = 5;
  localparam int unsigned RP_W       = 10;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned IN_DATA_W  = ((PAGE_W + CS_W + 7) / 8) * 8;

  // 64 page bits per store word
  localparam int unsigned WORD_SHIFT = 6;

  // largest region_pages value the register can hold
  localparam int unsigned MAX_RP = (1 << RP_W) - 1;

  // register reset values
  localparam logic [SS_W-1:0] SS_RESET = SS_W'(12);
  localparam logic [RP_W-1:0] RP_RESET = RP_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOGGING      = 2'd0,
    REG_SERVER_SHIFT = 2'd1,
    REG_REGION_PAGES = 2'd2
  } cfg_reg_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_LOG_OFF   = 2'd1,
    STATUS_TOO_LARGE = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_MARK = 1'b0,
    FUNC_GET  = 1'b1
  } func_e;

  // configuration view handed to the sequencer
  typedef struct packed {
    logic            logging;
    logic [SS_W-1:0] ss;
    logic [RP_W-1:0] pages;
    logic            clr_req;
  } cfg_t;

endpackage

@@ rtl/core/dbpr_ram.sv @@
module dbpr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dbpr_cfg.sv @@
module dbpr_cfg #(
  parameter int unsigned REGION_PAGES = dbpr_pkg::REGION_PAGES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dbpr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dbpr_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             clr_ack_i,
  output dbpr_pkg::cfg_t                   cfg_o
);

  import dbpr_pkg::*;

  logic            logging_q, logging_d;
  logic [SS_W-1:0] ss_q, ss_d;
  logic [RP_W-1:0] rp_q, rp_d;
  logic            clr_req_q, clr_req_d;
  logic            clr_set;
  logic [RP_W-1:0] pages;

  always_comb begin
    logging_d = logging_q;
    ss_d      = ss_q;
    rp_d      = rp_q;
    clr_set   = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LOGGING: begin
          // store is wiped when logging goes off or is switched on
          if (!cfg_data_i[0] || !logging_q) begin
            clr_set = 1'b1;
          end
          logging_d = cfg_data_i[0];
        end
        REG_SERVER_SHIFT: begin
          if (!logging_q) begin
            ss_d = cfg_data_i[SS_W-1:0];
          end
        end
        REG_REGION_PAGES: begin
          if (!logging_q) begin
            rp_d = cfg_data_i[RP_W-1:0];
          end
        end
        default: ;
      endcase
    end
    clr_req_d = clr_set | (clr_req_q & ~clr_ack_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logging_q <= 1'b0;
      ss_q      <= SS_RESET;
      rp_q      <= RP_RESET;
      clr_req_q <= 1'b1;
    end else begin
      logging_q <= logging_d;
      ss_q      <= ss_d;
      rp_q      <= rp_d;
      clr_req_q <= clr_req_d;
    end
  end

  // page count saturated at the store size
  assign pages = (32'(rp_q) > REGION_PAGES) ? RP_W'(REGION_PAGES) : rp_q;

  assign cfg_o = '{logging: logging_q, ss: ss_q, pages: pages, clr_req: clr_req_q};

  a_size_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_idx_i == REG_SERVER_SHIFT) && logging_q |=> $stable(ss_q))
    else $error("server page shift changed while logging");

endmodule

@@ rtl/core/dbpr_seq.sv @@
module dbpr_seq #(
  parameter int unsigned REGION_PAGES = dbpr_pkg::REGION_PAGES_DEF,
  parameter int unsigned OUT_WORDS    = dbpr_pkg::OUT_WORDS_DEF,
  parameter int unsigned AW           = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dbpr_pkg::cfg_t                  cfg_i,
  output logic                            clr_ack_o,
  // input words
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            in_func_i,
  input  logic [dbpr_pkg::PAGE_W-1:0]     in_page_i,
  input  logic [dbpr_pkg::CS_W-1:0]       in_cs_i,
  // dirty store port
  output logic                            ram_we_o,
  output logic [AW-1:0]                   ram_addr_o,
  output logic [dbpr_pkg::WORD_W-1:0]     ram_wdata_o,
  input  logic [dbpr_pkg::WORD_W-1:0]     ram_rdata_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [dbpr_pkg::WORD_W-1:0]     out_word_o,
  output logic                            out_last_o,
  output logic [dbpr_pkg::STATUS_W-1:0]   out_status_o
);

  import dbpr_pkg::*;

  localparam int unsigned StoreWords = (REGION_PAGES + 63) / 64;
  localparam int unsigned Limit      = OUT_WORDS * 64;
  localparam int unsigned MaxSteps   = (Limit > MAX_RP) ? Limit : MAX_RP;
  localparam int unsigned StepW      = $clog2(MaxSteps + 1);
  localparam int unsigned ClientW    = $clog2(Limit);
  localparam int unsigned CbitsW     = RP_W + StepW;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MARK_WR = 6'b000010,
    ST_SETUP   = 6'b000100,
    ST_LATCH   = 6'b001000,
    ST_SCAN    = 6'b010000,
    ST_CLEAR   = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [RP_W-1:0]      p_q, p_d;
  logic [ClientW-1:0]   c_q, c_d;
  logic [StepW-1:0]     r_q, r_d, i_q, i_d, n_q, n_d, mask_q, mask_d;
  logic                 rep_q, rep_d;
  logic [WORD_W-1:0]    word_q, word_d, acc_q, acc_d;
  logic [CS_W-1:0]      cs_q, cs_d;
  logic [PAGE_W-1:0]    page_q, page_d;
  logic [AW-1:0]        clr_addr_q, clr_addr_d;

  logic                 out_valid_q, out_valid_d, out_load;
  logic [WORD_W-1:0]    out_word_q, out_word_d;
  logic                 out_last_q, out_last_d;
  status_e              out_status_q, out_status_d;

  logic [RP_W-1:0]      ram_page;
  logic                 slot_free;

  // get setup: mode, shift distance and client bit count
  logic [CS_W-1:0]      su_ss, su_d, su_dd;
  logic                 su_rep;
  logic [StepW:0]       su_pow;
  logic [StepW-1:0]     su_mask, su_n;
  logic [CbitsW-1:0]    su_cbits;
  logic                 su_large;

  // one scan step
  logic                 sc_bit, sc_wrap, sc_c_inc, sc_p_inc, sc_last, sc_emit, sc_reload;
  logic [WORD_W-1:0]    sc_acc;

  assign slot_free = ~out_valid_q | out_ready_i;

  always_comb begin
    su_ss    = CS_W'(cfg_i.ss);
    su_rep   = (cs_q <= su_ss);
    su_d     = su_rep ? (su_ss - cs_q) : (cs_q - su_ss);
    su_dd    = (su_d > CS_W'(StepW)) ? CS_W'(StepW) : su_d;
    su_pow   = (StepW + 1)'(1) << su_dd;
    su_mask  = StepW'(su_pow - 1'b1);
    su_cbits = su_rep ? (CbitsW'(cfg_i.pages) << su_dd)
                      : ((CbitsW'(cfg_i.pages) + CbitsW'(su_mask)) >> su_dd);
    su_large = (su_cbits > CbitsW'(Limit));
    su_n     = su_rep ? StepW'(su_cbits) : StepW'(cfg_i.pages);
  end

  always_comb begin
    sc_bit    = word_q[p_q[WORD_SHIFT-1:0]];
    sc_acc    = acc_q | (WORD_W'(sc_bit) << c_q[WORD_SHIFT-1:0]);
    sc_wrap   = (r_q == mask_q);
    sc_c_inc  = rep_q | sc_wrap;
    sc_p_inc  = ~rep_q | sc_wrap;
    sc_last   = (i_q == n_q - StepW'(1));
    sc_emit   = sc_last | (sc_c_inc & (&c_q[WORD_SHIFT-1:0]));
    sc_reload = ~sc_last & sc_p_inc & (&p_q[WORD_SHIFT-1:0]);
  end

  always_comb begin
    state_d      = state_q;
    p_d          = p_q;
    c_d          = c_q;
    r_d          = r_q;
    i_d          = i_q;
    n_d          = n_q;
    mask_d       = mask_q;
    rep_d        = rep_q;
    word_d       = word_q;
    acc_d        = acc_q;
    cs_d         = cs_q;
    page_d       = page_q;
    clr_addr_d   = clr_addr_q;
    clr_ack_o    = 1'b0;
    ram_we_o     = 1'b0;
    ram_wdata_o  = '0;
    ram_page     = '0;
    out_load     = 1'b0;
    out_word_d   = out_word_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;

    unique case (state_q)
      ST_IDLE: begin
        ram_page = RP_W'(in_page_i);
        if (cfg_i.clr_req) begin
          clr_ack_o  = 1'b1;
          clr_addr_d = '0;
          state_d    = ST_CLEAR;
        end else if (in_valid_i) begin
          if (in_func_i == FUNC_GET) begin
            cs_d    = in_cs_i;
            state_d = ST_SETUP;
          end else if (cfg_i.logging && (RP_W'(in_page_i) < cfg_i.pages)) begin
            page_d  = in_page_i;
            state_d = ST_MARK_WR;
          end
        end
      end

      ST_MARK_WR: begin
        ram_page    = RP_W'(page_q);
        ram_we_o    = 1'b1;
        ram_wdata_o = ram_rdata_i | (WORD_W'(1) << page_q[WORD_SHIFT-1:0]);
        state_d     = ST_IDLE;
      end

      ST_SETUP: begin
        ram_page = '0;
        if (!cfg_i.logging || su_large || (su_n == '0)) begin
          // single-word answer: error or empty region
          if (slot_free) begin
            out_load   = 1'b1;
            out_word_d = '0;
            out_last_d = 1'b1;
            if (!cfg_i.logging) begin
              out_status_d = STATUS_LOG_OFF;
            end else if (su_large) begin
              out_status_d = STATUS_TOO_LARGE;
            end else begin
              out_status_d = STATUS_OK;
            end
            state_d = ST_IDLE;
          end
        end else begin
          rep_d   = su_rep;
          mask_d  = su_mask;
          n_d     = su_n;
          p_d     = '0;
          c_d     = '0;
          r_d     = '0;
          i_d     = '0;
          acc_d   = '0;
          state_d = ST_LATCH;
        end
      end

      ST_LATCH: begin
        // capture the store word and clear it behind the read
        ram_page    = p_q;
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
        word_d      = ram_rdata_i;
        state_d     = ST_SCAN;
      end

      ST_SCAN: begin
        ram_page = p_q + RP_W'(1);
        if (!sc_emit || slot_free) begin
          r_d = sc_wrap ? '0 : (r_q + StepW'(1));
          i_d = i_q + StepW'(1);
          if (sc_c_inc) begin
            c_d = c_q + ClientW'(1);
          end
          if (sc_p_inc) begin
            p_d = p_q + RP_W'(1);
          end
          if (sc_emit) begin
            out_load     = 1'b1;
            out_word_d   = sc_acc;
            out_last_d   = sc_last;
            out_status_d = STATUS_OK;
            acc_d        = '0;
          end else begin
            acc_d = sc_acc;
          end
          if (sc_last) begin
            state_d = ST_IDLE;
          end else if (sc_reload) begin
            state_d = ST_LATCH;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_wdata_o = '0;
        if (cfg_i.clr_req) begin
          // fresh request restarts the sweep
          clr_ack_o  = 1'b1;
          clr_addr_d = '0;
        end else if (clr_addr_q == AW'(StoreWords - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + AW'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign ram_addr_o = (state_q == ST_CLEAR) ? clr_addr_q : AW'(ram_page >> WORD_SHIFT);

  assign out_valid_d = out_load | (out_valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q          <= p_d;
    c_q          <= c_d;
    r_q          <= r_d;
    i_q          <= i_d;
    n_q          <= n_d;
    mask_q       <= mask_d;
    rep_q        <= rep_d;
    word_q       <= word_d;
    acc_q        <= acc_d;
    cs_q         <= cs_d;
    page_q       <= page_d;
    clr_addr_q   <= clr_addr_d;
    out_word_q   <= out_word_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign in_ready_o   = (state_q == ST_IDLE) & ~cfg_i.clr_req;
  assign out_valid_o  = out_valid_q;
  assign out_word_o   = out_word_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (i_q < n_q))
    else $error("scan step past the step count");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q != STATUS_OK) |-> out_last_q && (out_word_q == '0))
    else $error("error word is not a lone zero word");

  a_latch_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LATCH) |-> ($past(state_q) == ST_SETUP) || ($past(state_q) == ST_SCAN))
    else $error("store word latched without a read");

  a_mark_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MARK_WR) |-> $past(in_valid_i && in_ready_o))
    else $error("mark write without an accepted word");

endmodule

@@ rtl/core/dirty_bitmap_page_resample.sv @@
// dirty page bitmap of one region, resampled to the client page size on read
//
// config port: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 logging enable,
//   1 server page shift, 2 region pages); sizes are frozen while logging is on
// s_axis: one word per request, tuser picks mark (0) or get (1)
//   mark: sets one page bit with a read-modify-write on the single store port
//   get: setup, then one scan step per cycle unless a due result word meets a full
//     output register, plus a store fetch for each 64-page store word; steps =
//     client bits when client pages are not larger than logging pages, else region
//     pages; each 64 client bits leave as one m_axis word, tlast on the final one;
//     error or empty answers are a single zero word
// the store word is zeroed as it is fetched, so a get that scans leaves the bitmap clear
// reset and any write that clears the bitmap start a sweep over all ceil(REGION_PAGES/64)
//   store words (8 by default) during which s_axis_tready stays low
// results sit in an output register; a stalled receiver only stops the scan
//   when the next word is due, and s_axis_tready stays low until a get is done
module dirty_bitmap_page_resample #(
  parameter int unsigned REGION_PAGES = dbpr_pkg::REGION_PAGES_DEF,
  parameter int unsigned OUT_WORDS    = dbpr_pkg::OUT_WORDS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [dbpr_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [dbpr_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [dbpr_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // page_index, client_page_shift
  input  logic                              s_axis_tuser,  // func
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [dbpr_pkg::WORD_W-1:0]       m_axis_tdata,  // client_word
  output logic                              m_axis_tlast,
  output logic [dbpr_pkg::STATUS_W-1:0]     m_axis_tuser   // status
);

  import dbpr_pkg::*;

  localparam int unsigned StoreWords = (REGION_PAGES + 63) / 64;
  localparam int unsigned AddrW      = (StoreWords > 1) ? $clog2(StoreWords) : 1;

  cfg_t              cfg;
  logic              clr_ack;
  logic              ram_we;
  logic [AddrW-1:0]  ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic [PAGE_W-1:0] in_page;
  logic [CS_W-1:0]   in_cs;

  // unpack request fields
  assign in_page = s_axis_tdata[PAGE_W-1:0];
  assign in_cs   = s_axis_tdata[PAGE_W +: CS_W];

  dbpr_cfg #(
    .REGION_PAGES (REGION_PAGES)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .clr_ack_i  (clr_ack),
    .cfg_o      (cfg)
  );

  // dirty bit store, one 64-bit word per 64 logging pages
  dbpr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (StoreWords),
    .AW    (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  dbpr_seq #(
    .REGION_PAGES (REGION_PAGES),
    .OUT_WORDS    (OUT_WORDS),
    .AW           (AddrW)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .clr_ack_o    (clr_ack),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_func_i    (s_axis_tuser),
    .in_page_i    (in_page),
    .in_cs_i      (in_cs),
    .ram_we_o     (ram_we),
    .ram_addr_o   (ram_addr),
    .ram_wdata_o  (ram_wdata),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_word_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_status_o (m_axis_tuser)
  );

endmodule

@@ dv/tb_dirty_bitmap_page_resample.sv @@
`timescale 1ns / 1ps

module tb_dirty_bitmap_page_resample;
  import dbpr_pkg::*;

  localparam int unsigned OUT_BITS    = OUT_WORDS_DEF * WORD_W;
  localparam int unsigned MAX_GAP     = 14;
  // covers a mark's read-modify-write and the clearing sweep with room to spare
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned PHASES      = 5;
  localparam int unsigned PHASE_ITEMS = 20;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  // index past the last register, must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              last;
    status_e           status;
  } client_word_t;

  // bitmap predictor plus the queue of client words still owed by the block
  class dirty_map_model;
    logic                        logging = 1'b0;
    logic [SS_W-1:0]             ss      = SS_RESET;
    logic [RP_W-1:0]             rp      = RP_RESET;
    logic [REGION_PAGES_DEF-1:0] dirty   = '0;
    client_word_t                pending[$];
    int unsigned                 faults  = 0;

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_LOGGING: begin
          if (!data[0] || !logging) dirty = '0;
          logging = data[0];
        end
        REG_SERVER_SHIFT: if (!logging) ss = data[SS_W-1:0];
        REG_REGION_PAGES: if (!logging) rp = data[RP_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_pages();
      return (rp > REGION_PAGES_DEF) ? REGION_PAGES_DEF : int'(rp);
    endfunction

    function void note_request(func_e func, logic [PAGE_W-1:0] page, logic [CS_W-1:0] cs);
      logic [OUT_BITS-1:0] cbits;
      longint unsigned     pages;
      longint unsigned     client_bits;
      longint unsigned     words;
      int unsigned         d;
      pages = eff_pages();
      if (func == FUNC_MARK) begin
        if (logging && page < pages) dirty[page] = 1'b1;
        return;
      end
      if (!logging) begin
        pending.push_back('{word: '0, last: 1'b1, status: STATUS_LOG_OFF});
        return;
      end
      if (cs >= ss) begin
        d = cs - ss;
        client_bits = (pages + (64'd1 << d) - 64'd1) >> d;
      end else begin
        d = ss - cs;
        client_bits = pages << d;
      end
      if (client_bits > OUT_BITS) begin
        pending.push_back('{word: '0, last: 1'b1, status: STATUS_TOO_LARGE});
        return;
      end
      cbits = '0;
      if (cs > ss) begin
        // larger client pages: OR each group of logging bits
        for (int p = 0; p < pages; p++) begin
          if (dirty[p]) cbits[p >> d] = 1'b1;
        end
      end else begin
        // equal or smaller client pages: repeat each logging bit
        for (int c = 0; c < client_bits; c++) cbits[c] = dirty[c >> d];
      end
      words = (client_bits + 63) / 64;
      if (words == 0) words = 1;
      for (int w = 0; w < words; w++) begin
        pending.push_back('{word: cbits[w*WORD_W +: WORD_W], last: (w == words - 1),
                            status: STATUS_OK});
      end
      dirty = '0;
    endfunction

    function void check_word(logic [WORD_W-1:0] word, logic last, logic [STATUS_W-1:0] status);
      client_word_t want;
      if (pending.size() == 0) begin
        $error("unexpected word: client_word %h last %0d status %0d", word, last, status);
        faults++;
        return;
      end
      want = pending.pop_front();
      if (word !== want.word) begin
        $error("client_word: expected %h, actual %h", want.word, word);
        faults++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, last);
        faults++;
      end
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        faults++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // page_index, client_page_shift
  logic                  s_axis_tuser;   // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [WORD_W-1:0]     m_axis_tdata;   // client_word
  logic                  m_axis_tlast;
  logic [STATUS_W-1:0]   m_axis_tuser;   // status

  dirty_map_model model = new;
  bit             src_steady  = 1'b0;
  bit             sink_steady = 1'b0;
  int unsigned    cycles      = 0;

  dirty_bitmap_page_resample u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $error("run timed out with %0d words outstanding", model.pending.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // wait per word, with the occasional stretch of back-to-back traffic
  function automatic int unsigned next_gap(bit steady);
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // called at a falling edge; leaves tvalid high when the next word follows at once
  task automatic send_item(input func_e func, input logic [PAGE_W-1:0] page,
                           input logic [CS_W-1:0] cs);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= IN_DATA_W'({cs, page});
    do @(posedge clk_i); while (!s_axis_tready);
    model.note_request(func, page, cs);
    @(negedge clk_i);
    if ($urandom_range(0, 15) == 0) src_steady = !src_steady;
    gap = next_gap(src_steady);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // stop sending, collect every owed word, then let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (model.pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model.write_reg(idx, data);
  endtask

  // new sizes with logging off, then logging on most of the time
  task automatic configure_random();
    logic [CFG_DATA_W-1:0] data;
    logic [SS_W-1:0]       ss_pick;
    logic [RP_W-1:0]       rp_pick;
    case ($urandom_range(0, 5))
      0:       ss_pick = '0;
      1:       ss_pick = 5'd31;
      2:       ss_pick = 5'd30;
      3:       ss_pick = 5'd12;
      default: ss_pick = SS_W'($urandom);
    endcase
    case ($urandom_range(0, 6))
      0:       rp_pick = 10'd1;
      1:       rp_pick = 10'd512;
      2:       rp_pick = 10'd1023;
      3:       rp_pick = 10'd64;
      4:       rp_pick = '0;
      default: rp_pick = RP_W'($urandom);
    endcase
    data = CFG_DATA_W'($urandom);
    data[0] = 1'b0;
    write_reg(REG_LOGGING, data);
    write_reg(REG_SERVER_SHIFT, {5'($urandom), ss_pick});
    write_reg(REG_REGION_PAGES, rp_pick);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    data = CFG_DATA_W'($urandom);
    data[0] = ($urandom_range(0, 5) != 0);
    write_reg(REG_LOGGING, data);
    // size writes while logging must not take effect
    if ($urandom_range(0, 1) == 0) write_reg(REG_SERVER_SHIFT, CFG_DATA_W'($urandom));
    if ($urandom_range(0, 2) == 0) write_reg(REG_REGION_PAGES, CFG_DATA_W'($urandom));
  endtask

  // mostly marks inside the region, gets near the logging page size
  task automatic random_item();
    int unsigned         pages;
    int                  shift;
    logic [PAGE_W-1:0]   page;
    logic [CS_W-1:0]     cs;
    pages = model.eff_pages();
    if ($urandom_range(0, 9) < 8) begin
      if (pages != 0 && $urandom_range(0, 7) != 0) page = PAGE_W'($urandom_range(0, pages - 1));
      else page = PAGE_W'($urandom);
      send_item(FUNC_MARK, page, CS_W'($urandom));
    end else begin
      if ($urandom_range(0, 4) != 0) begin
        shift = int'(model.ss) + int'($urandom_range(0, 6)) - 3;
        if (shift < 0) shift = 0;
        cs = CS_W'(shift);
      end else begin
        cs = CS_W'($urandom);
      end
      send_item(FUNC_GET, PAGE_W'($urandom), cs);
    end
  endtask

  // result side: random stall before each word, checked at the accepting edge
  initial begin
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
      stall = next_gap(sink_steady);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      model.check_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      @(negedge clk_i);
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_LOGGING;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = FUNC_MARK;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    // reset clearing sweep
    drain();

    // logging off after reset: get reports it, mark is dropped
    send_item(FUNC_GET, '0, 6'd12);
    send_item(FUNC_MARK, 9'd5, '0);
    drain();
    write_reg(REG_UNUSED, '1);
    write_reg(REG_SERVER_SHIFT, 10'd12);
    write_reg(REG_REGION_PAGES, 10'd512);
    write_reg(REG_LOGGING, 10'd1);

    // region edges and store word boundaries, read back 1:1
    send_item(FUNC_MARK, 9'd0, '0);
    send_item(FUNC_MARK, 9'd511, '0);
    send_item(FUNC_MARK, 9'd300, '0);
    send_item(FUNC_MARK, 9'd63, '0);
    send_item(FUNC_MARK, 9'd64, '0);
    send_item(FUNC_GET, '1, 6'd12);
    // too large leaves the store alone, the OR of everything follows
    send_item(FUNC_MARK, 9'd511, '1);
    send_item(FUNC_GET, '0, 6'd0);
    send_item(FUNC_GET, '0, 6'd63);
    // pairs ORed
    send_item(FUNC_MARK, 9'd7, '0);
    send_item(FUNC_GET, '0, 6'd13);
    // each bit repeated 8 times fills the full 64-word bound, then one past it
    send_item(FUNC_MARK, 9'd100, '0);
    send_item(FUNC_GET, '0, 6'd9);
    send_item(FUNC_GET, '0, 6'd8);
    send_item(FUNC_MARK, 9'd200, '0);
    drain();

    // size writes while logging are ignored, re-enabling keeps the bitmap
    write_reg(REG_SERVER_SHIFT, 10'd5);
    write_reg(REG_REGION_PAGES, 10'd3);
    write_reg(REG_LOGGING, 10'd1);
    send_item(FUNC_GET, '0, 6'd12);
    drain();

    // empty region: one zero word
    write_reg(REG_LOGGING, 10'd0);
    write_reg(REG_REGION_PAGES, 10'd0);
    write_reg(REG_SERVER_SHIFT, 10'd31);
    write_reg(REG_LOGGING, 10'd1);
    send_item(FUNC_MARK, 9'd0, '0);
    send_item(FUNC_GET, '0, 6'd0);
    drain();

    // oversized region count saturates, smallest logging page
    write_reg(REG_LOGGING, 10'd0);
    write_reg(REG_REGION_PAGES, 10'd1023);
    write_reg(REG_SERVER_SHIFT, 10'd0);
    write_reg(REG_LOGGING, 10'd1);
    send_item(FUNC_MARK, 9'd511, '0);
    send_item(FUNC_MARK, 9'd0, '0);
    send_item(FUNC_GET, '0, 6'd40);
    send_item(FUNC_GET, '0, 6'd0);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      configure_random();
      for (int k = 0; k < PHASE_ITEMS; k++) random_item();
    end
    drain();

    if (model.faults == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ dirty_bitmap_page_resample.f @@
rtl/core/dbpr_pkg.sv
rtl/core/dbpr_ram.sv
rtl/core/dbpr_cfg.sv
rtl/core/dbpr_seq.sv
rtl/core/dirty_bitmap_page_resample.sv
dv/tb_dirty_bitmap_page_resample.sv
